### hdl/tpf_pkg.sv
// Shared types, constants and helpers for the two-distinct-prime-factor counter.
// No dependencies; every other file takes names from here by scope.
package tpf_pkg;

   // Fixed field widths of the channel words
   localparam int N_W     = 13;
   localparam int TALLY_W = 13;

   // Per-number store entry: distinct-prime count, saturating
   localparam int STORE_W = 2;
   localparam logic [STORE_W-1:0] COUNT_ZERO = 2'd0;
   localparam logic [STORE_W-1:0] COUNT_TWO  = 2'd2;
   localparam logic [STORE_W-1:0] COUNT_SAT  = 2'd3;

   localparam int DEFAULT_MAX_N = 4096;
   localparam int FIRST_PRIME   = 2;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_SIEVE = 5'b00100,
      ST_MARK  = 5'b01000,
      ST_COUNT = 5'b10000
   } state_type;

   function automatic logic [STORE_W-1:0] sat_inc(input logic [STORE_W-1:0] v);
      return (v == COUNT_SAT) ? v : v + 2'd1;
   endfunction

endpackage

### hdl/tpf_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on tpf_pkg for the field widths.
interface tpf_req_if;
   logic                      valid;
   logic                      ready;
   logic [tpf_pkg::N_W-1:0]   n_limit;

   modport source (output valid, output n_limit, input ready);
   modport sink   (input valid, input n_limit, output ready);
endinterface

interface tpf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpf_pkg::TALLY_W-1:0] almost_prime_count;

   modport source (output valid, output almost_prime_count, input ready);
   modport sink   (input valid, input almost_prime_count, output ready);
endinterface

### hdl/tpf_store.sv
// Per-number distinct-prime count memory: one write port, one registered read port.
// Depends on tpf_pkg for the entry width.
module tpf_store #(
   parameter int MAX_N = tpf_pkg::DEFAULT_MAX_N
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_N+1)-1:0]    wr_addr,
   input  logic [tpf_pkg::STORE_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_N+1)-1:0]    rd_addr,
   output logic [tpf_pkg::STORE_W-1:0]   rd_data
);

   localparam int DEPTH = MAX_N + 1;

   logic [tpf_pkg::STORE_W-1:0] mem_ff [DEPTH];
   logic [tpf_pkg::STORE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/tpf_step_unit.sv
// Shared cursor arithmetic: one adder for every advance and one bound compare.
// Depends on tpf_pkg for the default bound.
module tpf_step_unit #(
   parameter int MAX_N = tpf_pkg::DEFAULT_MAX_N
) (
   input  logic [$clog2(MAX_N+1):0]    addend_a,
   input  logic [$clog2(MAX_N+1):0]    addend_b,
   input  logic [$clog2(MAX_N+1):0]    cursor,
   input  logic [$clog2(MAX_N+1)-1:0]  limit,
   output logic [$clog2(MAX_N+1):0]    sum,
   output logic                        cursor_le
);

   // Sums never exceed twice the bound, so one extra bit suffices
   assign sum       = addend_a + addend_b;
   assign cursor_le = (cursor <= {1'b0, limit});

endmodule

### hdl/two_distinct_prime_factor_counter_top.sv
// Top level of the two-distinct-prime-factor counter: sequencer, result register.
// Depends on tpf_pkg, tpf_if, tpf_store and tpf_step_unit.
//
//   channel   | dir | handshake           | word
//   ----------+-----+---------------------+-------------------------------------
//   req_ch    | in  | valid/ready         | n_limit, 13 bits, clamped to MAX_N
//   rsp_ch    | out | valid/ready         | almost_prime_count, 13 bits
//
// A word passes through idle, which takes it, clear, which zeroes store entries
// 0..n for n after clamping, sieve, which tests candidates up to n, mark, which
// bumps the count of every multiple of each prime found, and count, which tallies
// the entries that hold two and loads the result. The store's single read and
// single write port set the pace. Reset is synchronous and returns the sequencer
// to idle with no result pending; the store is not reset, as each word clears it.
// req_ch is ready only in idle; a finished result waits in its own register,
// so the next word is taken while it sits unconsumed on rsp_ch.
module two_distinct_prime_factor_counter_top #(
   parameter int MAX_N = tpf_pkg::DEFAULT_MAX_N
) (
   input  logic       clock,
   input  logic       reset,
   tpf_req_if.sink    req_ch,
   tpf_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(MAX_N + 1);   // store index width
   localparam int AW = IW + 1;              // cursor width, holds up to 2*MAX_N
   localparam int LW = (IW > tpf_pkg::N_W) ? IW : tpf_pkg::N_W;
   localparam logic [LW-1:0] MAX_N_L = LW'(MAX_N);
   localparam logic [AW-1:0] FIRST_P = AW'(tpf_pkg::FIRST_PRIME);
   localparam logic [AW-1:0] ONE_A   = AW'(1);

   tpf_pkg::state_type state_ff, state_in;

   logic [IW-1:0]               n_ff, n_in;
   logic [AW-1:0]               cursor_ff, cursor_in;
   logic [IW-1:0]               prime_ff, prime_in;
   logic                        pend_ff, pend_in;          // read issued last cycle
   logic [IW-1:0]               pend_addr_ff, pend_addr_in;
   logic [tpf_pkg::TALLY_W-1:0] tally_ff, tally_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tpf_pkg::TALLY_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        mem_we, mem_re;
   logic [IW-1:0]               mem_waddr;
   logic [tpf_pkg::STORE_W-1:0] mem_wdata, mem_rdata;

   logic [AW-1:0]               op_a, op_b, step_sum;
   logic                        cursor_le;
   logic [LW-1:0]               n_ext, n_clamped;
   logic                        load_rsp;

   // Clamp the requested limit to the store size
   assign n_ext     = LW'(req_ch.n_limit);
   assign n_clamped = (n_ext > MAX_N_L) ? MAX_N_L : n_ext;

   tpf_store #(.MAX_N(MAX_N)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (cursor_ff[IW-1:0]),
      .rd_data (mem_rdata)
   );

   tpf_step_unit #(.MAX_N(MAX_N)) u_step (
      .addend_a  (op_a),
      .addend_b  (op_b),
      .cursor    (cursor_ff),
      .limit     (n_ff),
      .sum       (step_sum),
      .cursor_le (cursor_le)
   );

   assign req_ch.ready              = (state_ff == tpf_pkg::ST_IDLE);
   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.almost_prime_count = rsp_count_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cursor_in    = cursor_ff;
      prime_in     = prime_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      tally_in     = tally_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = cursor_ff[IW-1:0];
      mem_wdata    = tpf_pkg::COUNT_ZERO;
      op_a         = cursor_ff;
      op_b         = ONE_A;
      load_rsp     = 1'b0;

      case (state_ff)
         tpf_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               n_in      = n_clamped[IW-1:0];
               cursor_in = '0;
               tally_in  = '0;
               pend_in   = 1'b0;
               state_in  = tpf_pkg::ST_CLEAR;
            end
         end

         tpf_pkg::ST_CLEAR: begin
            // Zero entries 0..n, one a cycle
            mem_we    = 1'b1;
            cursor_in = step_sum;
            if (cursor_ff == {1'b0, n_ff}) begin
               cursor_in = FIRST_P;
               state_in  = tpf_pkg::ST_SIEVE;
            end
         end

         tpf_pkg::ST_SIEVE: begin
            // Stream candidates; a zero count marks a prime
            if (pend_ff && (mem_rdata == tpf_pkg::COUNT_ZERO)) begin
               prime_in  = pend_addr_ff;
               cursor_in = {1'b0, pend_addr_ff};
               pend_in   = 1'b0;
               state_in  = tpf_pkg::ST_MARK;
            end else if (cursor_le) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cursor_ff[IW-1:0];
               cursor_in    = step_sum;
            end else begin
               pend_in   = 1'b0;
               cursor_in = FIRST_P;
               state_in  = tpf_pkg::ST_COUNT;
            end
         end

         tpf_pkg::ST_MARK: begin
            // Read one multiple while writing back the previous one
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = tpf_pkg::sat_inc(mem_rdata);
            end
            if (cursor_le) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cursor_ff[IW-1:0];
               op_b         = {1'b0, prime_ff};
               cursor_in    = step_sum;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // Resume the candidate scan just past this prime
                  op_a      = {1'b0, prime_ff};
                  cursor_in = step_sum;
                  state_in  = tpf_pkg::ST_SIEVE;
               end
            end
         end

         tpf_pkg::ST_COUNT: begin
            if (pend_ff && (mem_rdata == tpf_pkg::COUNT_TWO)) begin
               tally_in = tally_ff + 1'b1;
            end
            if (cursor_le) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = cursor_ff[IW-1:0];
               cursor_in    = step_sum;
            end else begin
               pend_in = 1'b0;
               // Hold until the result register is free
               if (!pend_ff && (!rsp_valid_ff || rsp_ch.ready)) begin
                  load_rsp = 1'b1;
                  state_in = tpf_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = tpf_pkg::ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_count_in = tally_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpf_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
         tally_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_ff    <= cursor_in;
         tally_ff     <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      prime_ff     <= prime_in;
      pend_addr_ff <= pend_addr_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Store writes happen only while clearing or marking
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == tpf_pkg::ST_CLEAR || state_ff == tpf_pkg::ST_MARK))
      else $error("store written outside clear or mark");

   // Every write lands inside 0..n
   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_waddr} <= {1'b0, n_ff}))
      else $error("store write beyond limit");

   // A multiple being written back is never below its prime
   a_mark_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpf_pkg::ST_MARK && pend_ff) |-> (pend_addr_ff >= prime_ff))
      else $error("marked entry below its prime");

   // Taking a word starts a fresh clear with an empty tally
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=>
         (state_ff == tpf_pkg::ST_CLEAR && tally_ff == '0 && cursor_ff == '0))
      else $error("item start did not reset the sweep");

endmodule

### bench/two_distinct_prime_factor_counter_top_test.sv
// Self-checking bench for two_distinct_prime_factor_counter_top: directed limits from a table,
// then random limits, each result checked against a hand count or an in-bench sieve.
// Depends on tpf_pkg, tpf_if and the block's RTL; reads no files.
module two_distinct_prime_factor_counter_top_test;

   // Allow for a run far slower than expected. A clamped limit sweeps the whole
   // store while a small limit sweeps only its head; even a run with every word
   // at the clamp stays well inside the bound.
   localparam int LIMIT_CYCLES  = 12_000_000;
   localparam int RANDOM_WORDS  = 80;
   localparam int SETTLE_CYCLES = 50;
   localparam int DIRECTED_ROWS = 22;
   localparam int FIELD_W       = tpf_pkg::N_W;

   typedef struct packed {
      logic [tpf_pkg::N_W-1:0]     limit;
      logic                        known;   // count typed in below rather than predicted
      logic [tpf_pkg::TALLY_W-1:0] count;
   } limit_case_type;

   typedef struct packed {
      logic [tpf_pkg::N_W-1:0]     limit;
      logic [tpf_pkg::TALLY_W-1:0] count;
   } awaited_tally_type;

   // Small and clamped limits, every bit of the field, and counts known by hand
   // (6 is the first number with two distinct primes; seven of them lie up to 20).
   limit_case_type directed_cases [DIRECTED_ROWS] = '{
      '{13'd0,    1'b1, 13'd0},
      '{13'd1,    1'b1, 13'd0},
      '{13'd2,    1'b1, 13'd0},
      '{13'd5,    1'b1, 13'd0},
      '{13'd6,    1'b1, 13'd1},
      '{13'd7,    1'b1, 13'd1},
      '{13'd10,   1'b1, 13'd2},
      '{13'd12,   1'b1, 13'd3},
      '{13'd20,   1'b1, 13'd7},
      '{13'd30,   1'b0, 13'd0},
      '{13'd64,   1'b0, 13'd0},
      '{13'd255,  1'b0, 13'd0},
      '{13'd256,  1'b0, 13'd0},
      '{13'd511,  1'b0, 13'd0},
      '{13'd1000, 1'b0, 13'd0},
      '{13'd2048, 1'b0, 13'd0},
      '{13'd4095, 1'b0, 13'd0},
      '{13'd4096, 1'b0, 13'd0},
      '{13'd4097, 1'b0, 13'd0},
      '{13'd5000, 1'b0, 13'd0},
      '{13'd8191, 1'b0, 13'd0},
      '{13'd17,   1'b0, 13'd0}
   };

   logic clock;
   logic reset;

   tpf_req_if req_ch ();
   tpf_rsp_if rsp_ch ();

   two_distinct_prime_factor_counter_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   awaited_tally_type awaited_tallies [$];
   int                mismatch_count  = 0;
   int                results_checked = 0;
   int                words_sent;
   int                clamped_words;
   int                cycle_count     = 0;
   bit                no_gaps;        // both sides run without idling while set

   // Working store of distinct-prime counts for the predictor
   logic [tpf_pkg::STORE_W-1:0] factor_count [0:tpf_pkg::DEFAULT_MAX_N];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Sieve the range 2..limit, clamped, and count the entries that saw two primes
   function automatic logic [tpf_pkg::TALLY_W-1:0] count_two_prime_numbers(
         input logic [tpf_pkg::N_W-1:0] limit);
      int                          top;
      logic [tpf_pkg::TALLY_W-1:0] tally;
      top = (limit > tpf_pkg::DEFAULT_MAX_N) ? tpf_pkg::DEFAULT_MAX_N : int'(limit);
      for (int i = 0; i <= top; i++)
         factor_count[i] = tpf_pkg::COUNT_ZERO;
      for (int p = tpf_pkg::FIRST_PRIME; p <= top; p++) begin
         if (factor_count[p] == tpf_pkg::COUNT_ZERO) begin
            for (int m = p; m <= top; m += p) begin
               if (factor_count[m] != tpf_pkg::COUNT_SAT)
                  factor_count[m] = factor_count[m] + 1'b1;
            end
         end
      end
      tally = '0;
      for (int i = tpf_pkg::FIRST_PRIME; i <= top; i++) begin
         if (factor_count[i] == tpf_pkg::COUNT_TWO)
            tally = tally + 1'b1;
      end
      return tally;
   endfunction

   // Offer one limit after a random gap, hold it until taken, then log what it must give
   task automatic send_limit(input logic [tpf_pkg::N_W-1:0] limit, input logic known,
                             input logic [tpf_pkg::TALLY_W-1:0] known_count);
      int                gap;
      awaited_tally_type entry;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.n_limit <= limit;
      do @(posedge clock); while (!req_ch.ready);
      entry.limit = limit;
      entry.count = known ? known_count : count_two_prime_numbers(limit);
      awaited_tallies = {awaited_tallies, entry};
      words_sent++;
      if (limit > tpf_pkg::DEFAULT_MAX_N)
         clamped_words++;
   endtask

   // Hold the sender until every outstanding result has been drained
   task automatic drain_results;
      req_ch.valid <= 1'b0;
      while (awaited_tallies.size() != 0)
         @(posedge clock);
   endtask

   // Result side: after each word taken, drop ready for a random hold, counted down
   // only while a word is on offer, so stalls land on fresh and waiting results.
   int rsp_hold;
   always @(posedge clock) begin : rsp_pacing
      int draw;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= $urandom_range(0, 7);
      end else if (rsp_ch.ready) begin
         if (rsp_ch.valid) begin
            draw = no_gaps ? 0 : $urandom_range(0, 7);
            if (draw != 0) begin
               rsp_ch.ready <= 1'b0;
               rsp_hold     <= draw - 1;
            end
         end
      end else if (rsp_ch.valid) begin
         if (rsp_hold == 0)
            rsp_ch.ready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   // Check every result taken against the oldest outstanding expectation
   always @(posedge clock) begin : tally_check
      awaited_tally_type head;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_tallies.size() == 0) begin
            $display("%0t: unexpected almost_prime_count word: expected none, got %0d",
                     $time, rsp_ch.almost_prime_count);
            mismatch_count++;
         end else begin
            head = awaited_tallies.pop_front();
            results_checked++;
            if (rsp_ch.almost_prime_count !== head.count) begin
               $display("%0t: almost_prime_count for n_limit %0d: expected %0d, got %0d",
                        $time, head.limit, head.count, rsp_ch.almost_prime_count);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timed out with %0d results outstanding",
                  $time, awaited_tallies.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [tpf_pkg::N_W-1:0] limit;
      int                      pick;
      words_sent      = 0;
      clamped_words   = 0;
      no_gaps         = 1'b0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.n_limit  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table
      for (int row = 0; row < DIRECTED_ROWS; row++)
         send_limit(directed_cases[row].limit, directed_cases[row].known,
                    directed_cases[row].count);
      drain_results();

      // Random part: mostly short limits, some medium, a few across the whole field
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 16 == 0)
            no_gaps <= ($urandom_range(0, 3) == 0);
         if (k == RANDOM_WORDS / 2)
            drain_results();
         pick = $urandom_range(0, 19);
         if (pick == 0)
            limit = FIELD_W'($urandom_range(0, 8191));
         else if (pick < 5)
            limit = FIELD_W'($urandom_range(0, 1023));
         else
            limit = FIELD_W'($urandom_range(0, 150));
         send_limit(limit, 1'b0, '0);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d limits (%0d directed, %0d above the clamp); %0d results checked",
               words_sent, DIRECTED_ROWS, clamped_words, results_checked);
      $display("Idling on both sides and drained pauses exercised; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && awaited_tallies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
